>>> sv/gnfs_pkg.sv
package gnfs_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DIMENSIONS   = 2'd0;
  localparam logic [1:0] REG_FRACTAL_MODE = 2'd1;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd2;

  // axis counts after zero is folded into one
  localparam logic [1:0] DIM_ONE = 2'd1;
  localparam logic [1:0] DIM_TWO = 2'd2;

  // settings seen by every octave cell
  typedef struct packed {
    logic [1:0] dims;
    logic       fractal;
    logic [3:0] octaves;
  } cfg_t;

  // lattice hash permutation
  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

>>> sv/gnfs_cell.sv
module gnfs_cell #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_OCTAVES = 8,
  parameter int IDX = 0,
  localparam int GW = FRAC_BITS + 3,
  localparam int AW = GW + MAX_OCTAVES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  gnfs_pkg::cfg_t       cfg,
  input  logic                 in_vld,
  input  logic [31:0]          in_x,
  input  logic [31:0]          in_y,
  input  logic [31:0]          in_z,
  output logic                 out_vld,
  output logic [31:0]          out_x,
  output logic [31:0]          out_y,
  output logic [31:0]          out_z,
  input  logic signed [AW-1:0] acc_in,
  output logic signed [AW-1:0] acc_out,
  output logic                 acc_vld
);

  localparam int F  = FRAC_BITS;
  localparam int DW = GW + 1;
  localparam int PW = DW + F + 2;
  localparam int L  = 12;
  localparam logic signed [GW-1:0] ONE_G = {3'b001, {F{1'b0}}};
  localparam logic [F+3:0] TEN_S = (F+4)'(10) << F;

  function automatic logic signed [GW-1:0] grad1(input logic [7:0] h,
                                                  input logic signed [GW-1:0] x);
    return h[0] ? -x : x;
  endfunction

  function automatic logic signed [GW-1:0] grad2(input logic [7:0] h,
                                                  input logic signed [GW-1:0] x,
                                                  input logic signed [GW-1:0] y);
    return (h[0] ? -x : x) + (h[1] ? -y : y);
  endfunction

  function automatic logic signed [GW-1:0] grad3(input logic [7:0] h,
                                                  input logic signed [GW-1:0] x,
                                                  input logic signed [GW-1:0] y,
                                                  input logic signed [GW-1:0] z);
    logic [3:0] k;
    logic signed [GW-1:0] p, q;
    k = h[3:0];
    p = (k < 4'd8) ? x : y;
    if (k < 4'd4) q = y;
    else if (k inside {4'd12, 4'd14}) q = x;
    else q = z;
    return (k[0] ? -p : p) + (k[1] ? -q : q);
  endfunction

  function automatic logic signed [PW-1:0] lprod(input logic signed [GW-1:0] a,
                                                  input logic signed [GW-1:0] b,
                                                  input logic [F:0] w);
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return PW'(d) * PW'(signed'({1'b0, w}));
  endfunction

  function automatic logic signed [GW-1:0] lfin(input logic signed [GW-1:0] a,
                                                 input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> F;
    return a + sh[GW-1:0];
  endfunction

  logic [L:1] vld;

  logic [7:0]     s1_ha, s1_hb, s1_hy, s1_hz;
  logic [F-1:0]   s1_fx, s1_fy, s1_fz;
  logic [2*F-1:0] s1_ttx, s1_tty, s1_ttz;

  logic [7:0]     s2_a, s2_b, s2_ha, s2_hb, s2_hz;
  logic [F-1:0]   s2_fx, s2_fy, s2_fz;
  logic [2*F-1:0] s2_t3x, s2_t3y, s2_t3z;
  logic [F+3:0]   s2_inx, s2_iny, s2_inz;

  logic [7:0]     s3_pa, s3_pb, s3_pa1, s3_pb1, s3_ha, s3_hb, s3_hz;
  logic [F-1:0]   s3_fx, s3_fy, s3_fz;
  logic [2*F+3:0] s3_fdx, s3_fdy, s3_fdz;

  logic [7:0]     s4_aa, s4_ba, s4_ab, s4_bb, s4_pa, s4_pb, s4_pa1, s4_pb1, s4_ha, s4_hb;
  logic [F-1:0]   s4_fx, s4_fy, s4_fz;
  logic [F:0]     s4_u, s4_v, s4_s;

  logic [7:0]     s5_h [8];
  logic [7:0]     s5_pa, s5_pb, s5_pa1, s5_pb1, s5_ha, s5_hb;
  logic [F-1:0]   s5_fx, s5_fy, s5_fz;
  logic [F:0]     s5_u, s5_v, s5_s;

  logic signed [GW-1:0] s6_g [8];
  logic [F:0]           s6_u, s6_v, s6_s;

  logic signed [PW-1:0] s7_p [4];
  logic signed [GW-1:0] s7_a [4];
  logic [F:0]           s7_v, s7_s;

  logic signed [GW-1:0] s8_x [4];
  logic [F:0]           s8_v, s8_s;

  logic signed [PW-1:0] s9_p [2];
  logic signed [GW-1:0] s9_a [2];
  logic [F:0]           s9_s;

  logic signed [GW-1:0] s10_y [2];
  logic [F:0]           s10_s;

  logic signed [PW-1:0] s11_p;
  logic signed [GW-1:0] s11_a;

  logic signed [GW-1:0] s12_n;

  logic [7:0]           cxi, cyi, czi;
  logic [F-1:0]         fxi, fyi, fzi;
  logic [F-1:0]         t2x, t2y, t2z;
  logic signed [GW-1:0] gx, gy, gz, gxm, gym, gzm;
  logic signed [GW-1:0] g [8];
  logic                 en;

  assign cxi = in_x[F+7:F];
  assign cyi = in_y[F+7:F];
  assign czi = in_z[F+7:F];
  assign fxi = in_x[F-1:0];
  assign fyi = in_y[F-1:0];
  assign fzi = in_z[F-1:0];

  assign t2x = s1_ttx[2*F-1:F];
  assign t2y = s1_tty[2*F-1:F];
  assign t2z = s1_ttz[2*F-1:F];

  assign gx  = signed'({3'b000, s5_fx});
  assign gy  = signed'({3'b000, s5_fy});
  assign gz  = signed'({3'b000, s5_fz});
  assign gxm = gx - ONE_G;
  assign gym = gy - ONE_G;
  assign gzm = gz - ONE_G;

  always_comb begin
    case (cfg.dims)
      gnfs_pkg::DIM_ONE: begin
        g[0] = grad1(s5_ha, gx);
        g[1] = grad1(s5_hb, gxm);
        for (int i = 2; i < 8; i++) g[i] = g[i%2];
      end
      gnfs_pkg::DIM_TWO: begin
        g[0] = grad2(s5_pa, gx, gy);
        g[1] = grad2(s5_pb, gxm, gy);
        g[2] = grad2(s5_pa1, gx, gym);
        g[3] = grad2(s5_pb1, gxm, gym);
        for (int i = 4; i < 8; i++) g[i] = g[i-4];
      end
      default: begin
        g[0] = grad3(s5_h[0], gx, gy, gz);
        g[1] = grad3(s5_h[1], gxm, gy, gz);
        g[2] = grad3(s5_h[2], gx, gym, gz);
        g[3] = grad3(s5_h[3], gxm, gym, gz);
        g[4] = grad3(s5_h[4], gx, gy, gzm);
        g[5] = grad3(s5_h[5], gxm, gy, gzm);
        g[6] = grad3(s5_h[6], gx, gym, gzm);
        g[7] = grad3(s5_h[7], gxm, gym, gzm);
      end
    endcase
  end

  assign en = cfg.fractal ? (cfg.octaves > 4'(IDX)) : (IDX == 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      acc_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[L-1:1], in_vld};
      acc_vld <= vld[L];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // hash the x cell, square the fractions
      out_x  <= in_x << 1;
      out_y  <= in_y << 1;
      out_z  <= in_z << 1;
      s1_ha  <= gnfs_pkg::PERM[cxi];
      s1_hb  <= gnfs_pkg::PERM[cxi + 8'd1];
      s1_hy  <= cyi;
      s1_hz  <= czi;
      s1_fx  <= fxi;
      s1_fy  <= fyi;
      s1_fz  <= fzi;
      s1_ttx <= fxi * fxi;
      s1_tty <= fyi * fyi;
      s1_ttz <= fzi * fzi;

      s2_a   <= s1_ha + s1_hy;
      s2_b   <= s1_hb + s1_hy;
      s2_ha  <= s1_ha;
      s2_hb  <= s1_hb;
      s2_hz  <= s1_hz;
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_fz  <= s1_fz;
      s2_t3x <= t2x * s1_fx;
      s2_t3y <= t2y * s1_fy;
      s2_t3z <= t2z * s1_fz;
      s2_inx <= TEN_S + ((F+4)'(t2x) << 2) + ((F+4)'(t2x) << 1)
                - (((F+4)'(s1_fx) << 4) - (F+4)'(s1_fx));
      s2_iny <= TEN_S + ((F+4)'(t2y) << 2) + ((F+4)'(t2y) << 1)
                - (((F+4)'(s1_fy) << 4) - (F+4)'(s1_fy));
      s2_inz <= TEN_S + ((F+4)'(t2z) << 2) + ((F+4)'(t2z) << 1)
                - (((F+4)'(s1_fz) << 4) - (F+4)'(s1_fz));

      s3_pa  <= gnfs_pkg::PERM[s2_a];
      s3_pb  <= gnfs_pkg::PERM[s2_b];
      s3_pa1 <= gnfs_pkg::PERM[s2_a + 8'd1];
      s3_pb1 <= gnfs_pkg::PERM[s2_b + 8'd1];
      s3_ha  <= s2_ha;
      s3_hb  <= s2_hb;
      s3_hz  <= s2_hz;
      s3_fx  <= s2_fx;
      s3_fy  <= s2_fy;
      s3_fz  <= s2_fz;
      s3_fdx <= s2_t3x[2*F-1:F] * s2_inx;
      s3_fdy <= s2_t3y[2*F-1:F] * s2_iny;
      s3_fdz <= s2_t3z[2*F-1:F] * s2_inz;

      s4_aa  <= s3_pa + s3_hz;
      s4_ba  <= s3_pb + s3_hz;
      s4_ab  <= s3_pa1 + s3_hz;
      s4_bb  <= s3_pb1 + s3_hz;
      s4_pa  <= s3_pa;
      s4_pb  <= s3_pb;
      s4_pa1 <= s3_pa1;
      s4_pb1 <= s3_pb1;
      s4_ha  <= s3_ha;
      s4_hb  <= s3_hb;
      s4_fx  <= s3_fx;
      s4_fy  <= s3_fy;
      s4_fz  <= s3_fz;
      s4_u   <= s3_fdx[2*F:F];
      s4_v   <= s3_fdy[2*F:F];
      s4_s   <= s3_fdz[2*F:F];

      s5_h[0] <= gnfs_pkg::PERM[s4_aa];
      s5_h[1] <= gnfs_pkg::PERM[s4_ba];
      s5_h[2] <= gnfs_pkg::PERM[s4_ab];
      s5_h[3] <= gnfs_pkg::PERM[s4_bb];
      s5_h[4] <= gnfs_pkg::PERM[s4_aa + 8'd1];
      s5_h[5] <= gnfs_pkg::PERM[s4_ba + 8'd1];
      s5_h[6] <= gnfs_pkg::PERM[s4_ab + 8'd1];
      s5_h[7] <= gnfs_pkg::PERM[s4_bb + 8'd1];
      s5_pa   <= s4_pa;
      s5_pb   <= s4_pb;
      s5_pa1  <= s4_pa1;
      s5_pb1  <= s4_pb1;
      s5_ha   <= s4_ha;
      s5_hb   <= s4_hb;
      s5_fx   <= s4_fx;
      s5_fy   <= s4_fy;
      s5_fz   <= s4_fz;
      s5_u    <= s4_u;
      s5_v    <= s4_v;
      s5_s    <= s4_s;

      for (int i = 0; i < 8; i++) s6_g[i] <= g[i];
      s6_u <= s5_u;
      s6_v <= s5_v;
      s6_s <= s5_s;

      // blend along x
      for (int i = 0; i < 4; i++) begin
        s7_p[i] <= lprod(s6_g[2*i], s6_g[2*i+1], s6_u);
        s7_a[i] <= s6_g[2*i];
      end
      s7_v <= s6_v;
      s7_s <= s6_s;

      for (int i = 0; i < 4; i++) s8_x[i] <= lfin(s7_a[i], s7_p[i]);
      s8_v <= s7_v;
      s8_s <= s7_s;

      // blend along y
      for (int i = 0; i < 2; i++) begin
        s9_p[i] <= lprod(s8_x[2*i], s8_x[2*i+1], s8_v);
        s9_a[i] <= s8_x[2*i];
      end
      s9_s <= s8_s;

      for (int i = 0; i < 2; i++) s10_y[i] <= lfin(s9_a[i], s9_p[i]);
      s10_s <= s9_s;

      // blend along z
      s11_p <= lprod(s10_y[0], s10_y[1], s10_s);
      s11_a <= s10_y[0];

      s12_n <= (cfg.dims == gnfs_pkg::DIM_ONE) ? (lfin(s11_a, s11_p) <<< 1)
                                                 : lfin(s11_a, s11_p);

      acc_out <= acc_in + (en ? (AW'(s12_n) <<< (MAX_OCTAVES - 1 - IDX)) : AW'(0));
    end
  end

  assign out_vld = vld[1];

endmodule

>>> sv/gradient_noise_fractal_sum_top.sv
// Improved 1-D to 3-D gradient noise with an optional fractal octave sum. Each request
// carries a signed Q16.16 coordinate triple (FRAC_BITS fraction bits) and
// returns one signed Q2.16 value, saturated. One request is taken every clock
// while the result side keeps up. Each request passes down the row of octave
// cells; each cell holds a 12-stage noise pipeline (hash lookups, fade
// multiplies, three lerp levels) and hands doubled coordinates to its neighbor
// through a register, while the weighted sum ripples down the row behind them.
// A stall on the result side freezes the whole row; the output register
// holds the waiting result. Configuration writes are always taken
// (cfg_ready stays high) and must only be issued while the block is empty.
module gradient_noise_fractal_sum_top #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               coord_valid,
  output logic               coord_stall,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               noise_valid,
  input  logic               noise_stall,
  output logic signed [17:0] noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int GW  = FRAC_BITS + 3;
  localparam int AW  = GW + MAX_OCTAVES;
  localparam int RW  = AW + 8;
  localparam int RSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int LSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [RW-1:0] SAT_HI = RW'(131071);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-131072);

  // configuration registers
  logic [1:0] dims;
  logic       fractal_mode;
  logic [3:0] octave_count;
  gnfs_pkg::cfg_t cfg;

  // the row advances whenever the output register is free or being emptied
  logic adv;

  // chain between cells
  logic [31:0]          cx [MAX_OCTAVES+1];
  logic [31:0]          cy [MAX_OCTAVES+1];
  logic [31:0]          cz [MAX_OCTAVES+1];
  logic                 cv [MAX_OCTAVES+1];
  logic signed [AW-1:0] acc [MAX_OCTAVES+1];
  logic                 accv [MAX_OCTAVES];

  logic signed [RW-1:0] sum_w, sum_sh, sum_sc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims         <= 2'd3;
      fractal_mode <= 1'b0;
      octave_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gnfs_pkg::REG_DIMENSIONS:   dims         <= cfg_data[1:0];
        gnfs_pkg::REG_FRACTAL_MODE: fractal_mode <= cfg_data[0];
        gnfs_pkg::REG_OCTAVE_COUNT: octave_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero axes behaves as one
  assign cfg.dims    = (dims == 2'd0) ? gnfs_pkg::DIM_ONE : dims;
  assign cfg.fractal = fractal_mode;
  assign cfg.octaves = octave_count;

  assign adv         = !noise_valid || !noise_stall;
  assign coord_stall = !adv;

  assign cx[0]  = coord_x;
  assign cy[0]  = coord_y;
  assign cz[0]  = coord_z;
  assign cv[0]  = coord_valid;
  assign acc[0] = '0;

  // one cell per octave, coordinates doubled from cell to cell
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    gnfs_cell #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_OCTAVES(MAX_OCTAVES),
      .IDX        (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .cfg    (cfg),
      .in_vld (cv[i]),
      .in_x   (cx[i]),
      .in_y   (cy[i]),
      .in_z   (cz[i]),
      .out_vld(cv[i+1]),
      .out_x  (cx[i+1]),
      .out_y  (cy[i+1]),
      .out_z  (cz[i+1]),
      .acc_in (acc[i]),
      .acc_out(acc[i+1]),
      .acc_vld(accv[i])
    );
  end

  // octave i was weighted by 2^(MAX-1-i); single mode only adds octave 0
  always_comb begin
    sum_w  = RW'(acc[MAX_OCTAVES]);
    sum_sh = fractal_mode ? (sum_w >>> MAX_OCTAVES) : (sum_w >>> (MAX_OCTAVES - 1));
    sum_sc = (sum_sh >>> RSH) <<< LSH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_valid <= 1'b0;
    end else if (adv) begin
      noise_valid <= accv[MAX_OCTAVES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum_sc > SAT_HI) noise_value <= SAT_HI[17:0];
      else if (sum_sc < SAT_LO) noise_value <= SAT_LO[17:0];
      else noise_value <= sum_sc[17:0];
    end
  end

  // a result only shows up when the last cell had one finished
  a_out_from_row: assert property (@(posedge clk) disable iff (rst)
    $rose(noise_valid) |-> $past(accv[MAX_OCTAVES-1]))
    else $error("result valid without a finished sum");

  // a taken request enters the first cell
  a_req_enters: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && !coord_stall) |=> cv[1])
    else $error("accepted request lost at the first cell");

  // a frozen row keeps its valid bits
  a_row_frozen: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(cv[1]) && $stable(accv[MAX_OCTAVES-1])))
    else $error("row moved while stalled");

endmodule
